// ===== hw/rtl/apru_pkg.sv =====
`default_nettype none
package apru_pkg;

    localparam int NUM_PROCESSES     = 8;
    localparam int PAGES_PER_PROCESS = 2048;
    localparam int NUM_FRAMES        = 4096;

    localparam int PID_W      = 3;
    localparam int PAGE_W     = $clog2(PAGES_PER_PROCESS);
    localparam int PG_CNT_W   = PAGE_W + 1;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int FC_W       = $clog2(NUM_FRAMES + 1);
    localparam int PICK_W     = 12;
    localparam int PT_DEPTH   = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int PT_AW      = $clog2(PT_DEPTH);
    localparam int CNT_W      = 16;
    localparam int THR_W      = 13;
    localparam int RSV_W      = 7;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0] COUNTER_FULL = '1;
    localparam logic [THR_W-1:0] THR_RESET    = 13'd1000;
    localparam logic [RSV_W-1:0] RSV_RESET    = 7'd10;

    localparam logic CFG_FREE_THRESHOLD = 1'b0;
    localparam logic CFG_RESERVED_PAGES = 1'b1;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_ACCESS  = 2'd1,
        ACT_AGE     = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_FILL       = 3'd1,
        ST_REPLACED   = 3'd2,
        ST_POOL_EMPTY = 3'd3,
        ST_NO_VICTIM  = 3'd4,
        ST_DONE       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CLS_SAME_PAGE  = 2'd0,
        CLS_UNOWNED    = 2'd1,
        CLS_SAME_OWNER = 2'd2,
        CLS_RANDOM     = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        PGM_START   = 2'd0,
        PGM_VICTIM  = 2'd1,
        PGM_AGE     = 2'd2,
        PGM_RELEASE = 2'd3
    } pg_mode_t;

    typedef enum logic {
        PLM_FREE   = 1'b0,
        PLM_CHOOSE = 1'b1
    } pl_mode_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic               valid;
        logic               refd;
        logic [FRAME_W-1:0] frame;
    } pte_t;

    typedef struct packed {
        logic              free;
        logic              owned;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } pool_ent_t;

    typedef struct packed {
        logic     clr_run;
        logic     latch;
        logic     hit_wr;
        logic     fill_wr;
        logic     st_map;
        logic     commit_a;
        logic     commit_b;
        logic     pg_init;
        logic     pg_run;
        pg_mode_t pg_mode;
        logic     pl_init;
        logic     pl_run;
        pl_mode_t pl_mode;
        logic     out_ld;
        status_t  st;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pe_valid;
        logic fc_gt_thr;
        logic fc_zero;
        logic vic_found;
        logic pg_hit;
        logic pg_end;
        logic pl_hit;
        logic pl_end;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/aging_page_replacement_unit_top.sv =====
// Aging page replacement unit: per-process page tables with aging counters and a
// tagged frame pool. Send one request per action (start, access, age, release) on
// the s_ stream and take one result per request on the m_ stream. After reset the
// unit runs a clearing pass over the page table (16384 entries, one entry a cycle,
// the frame pool is cleared in the same pass) and accepts no request until it ends;
// configuration writes are taken at any time but must only be issued while idle.
// Requests are served by scans of the page table and frame pool at one entry a
// cycle: an access hit reads and updates one entry; a free fill scans the pool for
// the lowest free frame; a replacement runs a victim scan, then one pass over the
// pool; aging scans the unreserved pages and release all pages of the process;
// start maps the reserved pages to free frames. A finished result waits in an
// output register while the next request is accepted.
`default_nettype none
module aging_page_replacement_unit_top
    import apru_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,  // pid, page_number, random_pick, zero pad
    input  wire logic [1:0]            s_tuser,  // action
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [39:0]           m_tdata,  // frame, attempt_class, victim_page,
                                                 // victim_frame, zero pad
    output logic      [2:0]            m_tuser,  // status
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;
    logic [FRAME_W-1:0] out_frame, out_vframe;
    logic [2:0]         out_status;
    logic [1:0]         out_cls;
    logic [PAGE_W-1:0]  out_vpage;

    // registers are always writable
    assign cfg_ready = 1'b1;

    apru_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser),
        .in_pid    (s_tdata[2:0]),
        .in_page   (s_tdata[13:3]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    apru_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_pid     (s_tdata[2:0]),
        .in_page    (s_tdata[13:3]),
        .in_pick    (s_tdata[25:14]),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .out_frame  (out_frame),
        .out_status (out_status),
        .out_cls    (out_cls),
        .out_vpage  (out_vpage),
        .out_vframe (out_vframe)
    );

    // result packing, lowest field first
    assign m_tdata = {3'b000, out_vframe, out_vpage, out_cls, out_frame};
    assign m_tuser = out_status;
endmodule
`default_nettype wire

// ===== hw/rtl/apru_ram.sv =====
`default_nettype none
module apru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/apru_ctrl.sv =====
`default_nettype none
module apru_ctrl
    import apru_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        in_action,
    input  wire logic [PID_W-1:0]  in_pid,
    input  wire logic [PAGE_W-1:0] in_page,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ctrl_cmd_t              cmd,
    input  wire dp_stat_t          stat
);
    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_LOOK   = 14'b00000000000100,
        S_DEC    = 14'b00000000001000,
        S_FILL   = 14'b00000000010000,
        S_ST_PG  = 14'b00000000100000,
        S_ST_PL  = 14'b00000001000000,
        S_VICT   = 14'b00000010000000,
        S_CHOOSE = 14'b00000100000000,
        S_COM_A  = 14'b00001000000000,
        S_COM_B  = 14'b00010000000000,
        S_AGE    = 14'b00100000000000,
        S_REL    = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    mv_reg, mv_next;
    action_t act;
    logic    pid_oor, page_oor;

    assign act      = action_t'(in_action);
    assign pid_oor  = {1'b0, in_pid} >= (PID_W+1)'(NUM_PROCESSES);
    assign page_oor = {1'b0, in_page} >= PG_CNT_W'(PAGES_PER_PROCESS);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        state_next  = state_reg;
        st_next     = st_reg;
        mv_next     = mv_reg;
        cmd         = '0;
        cmd.pg_mode = PGM_START;
        cmd.pl_mode = PLM_FREE;
        cmd.st      = st_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_run = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    if (pid_oor || (act == ACT_ACCESS && page_oor)) begin
                        st_next    = ST_DONE;
                        state_next = S_DONE;
                    end else begin
                        unique case (act)
                            ACT_START: begin
                                cmd.pg_init = 1'b1;
                                cmd.pg_mode = PGM_START;
                                cmd.pl_init = 1'b1;
                                state_next  = S_ST_PG;
                            end
                            ACT_ACCESS: state_next = S_LOOK;
                            ACT_AGE: begin
                                cmd.pg_init = 1'b1;
                                cmd.pg_mode = PGM_AGE;
                                state_next  = S_AGE;
                            end
                            ACT_RELEASE: begin
                                cmd.pg_init = 1'b1;
                                cmd.pg_mode = PGM_RELEASE;
                                state_next  = S_REL;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_LOOK: state_next = S_DEC;
            S_DEC: begin
                if (stat.pe_valid) begin
                    cmd.hit_wr = 1'b1;
                    st_next    = ST_HIT;
                    state_next = S_DONE;
                end else if (stat.fc_gt_thr) begin
                    cmd.pl_init = 1'b1;
                    state_next  = S_FILL;
                end else begin
                    cmd.pg_init = 1'b1;
                    cmd.pg_mode = PGM_VICTIM;
                    state_next  = S_VICT;
                end
            end
            S_FILL: begin
                cmd.pl_run = 1'b1;
                if (stat.pl_hit) begin
                    cmd.fill_wr = 1'b1;
                    st_next     = ST_FILL;
                    state_next  = S_DONE;
                end else if (stat.pl_end) begin
                    st_next    = ST_POOL_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_ST_PG: begin
                cmd.pg_run = 1'b1;
                if (stat.pg_hit) begin
                    state_next = S_ST_PL;
                end else if (stat.pg_end) begin
                    st_next    = ST_DONE;
                    state_next = S_DONE;
                end
            end
            S_ST_PL: begin
                cmd.pl_run = 1'b1;
                if (stat.pl_hit) begin
                    cmd.st_map = 1'b1;
                    state_next = S_ST_PG;
                end else if (stat.pl_end) begin
                    st_next    = ST_POOL_EMPTY;
                    state_next = S_DONE;
                end
            end
            S_VICT: begin
                cmd.pg_run  = 1'b1;
                cmd.pg_mode = PGM_VICTIM;
                if (stat.pg_end) begin
                    if (!stat.vic_found) begin
                        st_next    = ST_NO_VICTIM;
                        state_next = S_DONE;
                    end else if (stat.fc_zero) begin
                        st_next    = ST_POOL_EMPTY;
                        state_next = S_DONE;
                    end else begin
                        cmd.pl_init = 1'b1;
                        state_next  = S_CHOOSE;
                    end
                end
            end
            S_CHOOSE: begin
                cmd.pl_run  = 1'b1;
                cmd.pl_mode = PLM_CHOOSE;
                if (stat.pl_end) begin
                    state_next = S_COM_A;
                end
            end
            S_COM_A: begin
                cmd.commit_a = 1'b1;
                state_next   = S_COM_B;
            end
            S_COM_B: begin
                cmd.commit_b = 1'b1;
                st_next      = ST_REPLACED;
                state_next   = S_DONE;
            end
            S_AGE: begin
                cmd.pg_run  = 1'b1;
                cmd.pg_mode = PGM_AGE;
                if (stat.pg_end) begin
                    st_next    = ST_DONE;
                    state_next = S_DONE;
                end
            end
            S_REL: begin
                cmd.pg_run  = 1'b1;
                cmd.pg_mode = PGM_RELEASE;
                if (stat.pg_end) begin
                    st_next    = ST_DONE;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    cmd.out_ld = 1'b1;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            st_reg    <= ST_DONE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            mv_reg    <= mv_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/apru_dp.sv =====
`default_nettype none
module apru_dp
    import apru_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    input  wire logic [PID_W-1:0]      in_pid,
    input  wire logic [PAGE_W-1:0]     in_page,
    input  wire logic [PICK_W-1:0]     in_pick,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic      [FRAME_W-1:0]    out_frame,
    output logic      [2:0]            out_status,
    output logic      [1:0]            out_cls,
    output logic      [PAGE_W-1:0]     out_vpage,
    output logic      [FRAME_W-1:0]    out_vframe
);
    localparam int PTE_W  = $bits(pte_t);
    localparam int POOL_W = $bits(pool_ent_t);

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [RSV_W-1:0] rsv_reg;
    logic [PG_CNT_W-1:0] rl;

    // latched request
    logic [PID_W-1:0]  pid_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PICK_W-1:0] pick_reg;

    logic [PT_AW-1:0] clr_reg;
    logic [FC_W-1:0]  fc_reg, fc_next;

    // page table stream
    logic [PG_CNT_W-1:0] pg_ptr_reg, pg_end_reg;
    logic                pg_vld_reg;
    logic [PAGE_W-1:0]   pg_idx_reg, st_page_reg;

    // frame pool stream
    logic [FC_W-1:0]    pl_ptr_reg;
    logic               pl_vld_reg;
    logic [FRAME_W-1:0] pl_idx_reg;

    // victim search
    logic               vic_found_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [PAGE_W-1:0]  best_page_reg;
    logic [FRAME_W-1:0] best_frame_reg;

    // frame choice, one candidate per class
    logic [3:0]         cand_vld_reg;
    logic [FRAME_W-1:0] cand_frame_reg [4];
    logic [FC_W-1:0]    k_reg;
    logic [FC_W-1:0]    fc_m1, pick_ext, pick_c;
    logic [FRAME_W-1:0] chosen;
    class_t             chosen_cls;

    logic [FRAME_W-1:0] res_frame_reg, res_vframe_reg;
    logic [1:0]         res_cls_reg;
    logic [PAGE_W-1:0]  res_vpage_reg;
    logic [FRAME_W-1:0] out_frame_reg, out_vframe_reg;
    logic [2:0]         out_status_reg;
    logic [1:0]         out_cls_reg;
    logic [PAGE_W-1:0]  out_vpage_reg;

    logic [PTE_W-1:0]   pt_rdata;
    logic [POOL_W-1:0]  pool_rdata;
    pte_t               pe_rd, pt_wd;
    pool_ent_t          pl_rd, pool_wd;
    logic               pt_we, pool_we;
    logic [PT_AW-1:0]   pt_waddr, pt_raddr;
    logic [FRAME_W-1:0] pool_waddr;

    logic pg_hit, pg_issue, pg_end, age_wr, rel_wr, vic_upd;
    logic pl_hit, pl_issue, pl_end, ch_upd;

    assign pe_rd = pte_t'(pt_rdata);
    assign pl_rd = pool_ent_t'(pool_rdata);

    assign rl = (PG_CNT_W'(rsv_reg) > PG_CNT_W'(PAGES_PER_PROCESS)) ?
                PG_CNT_W'(PAGES_PER_PROCESS) : PG_CNT_W'(rsv_reg);

    assign pg_hit   = cmd.pg_run && cmd.pg_mode == PGM_START && pg_vld_reg && !pe_rd.valid;
    assign pg_issue = cmd.pg_run && (pg_ptr_reg < pg_end_reg) && !pg_hit;
    assign pg_end   = (pg_ptr_reg >= pg_end_reg) && !pg_vld_reg;
    assign age_wr   = cmd.pg_run && cmd.pg_mode == PGM_AGE && pg_vld_reg && pe_rd.valid;
    assign rel_wr   = cmd.pg_run && cmd.pg_mode == PGM_RELEASE && pg_vld_reg && pe_rd.valid;
    assign vic_upd  = cmd.pg_run && cmd.pg_mode == PGM_VICTIM && pg_vld_reg && pe_rd.valid &&
                      (!vic_found_reg || pe_rd.cnt < best_cnt_reg);

    assign pl_hit   = cmd.pl_run && cmd.pl_mode == PLM_FREE && pl_vld_reg && pl_rd.free;
    assign pl_issue = cmd.pl_run && (pl_ptr_reg < FC_W'(NUM_FRAMES)) && !pl_hit;
    assign pl_end   = (pl_ptr_reg >= FC_W'(NUM_FRAMES)) && !pl_vld_reg;
    assign ch_upd   = cmd.pl_run && cmd.pl_mode == PLM_CHOOSE && pl_vld_reg && pl_rd.free;

    // random pick clamped to the last free position
    assign fc_m1    = fc_reg - 1'b1;
    assign pick_ext = FC_W'(pick_reg);
    assign pick_c   = (pick_ext > fc_m1) ? fc_m1 : pick_ext;

    always_comb begin
        if (cand_vld_reg[0]) begin
            chosen     = cand_frame_reg[0];
            chosen_cls = CLS_SAME_PAGE;
        end else if (cand_vld_reg[1]) begin
            chosen     = cand_frame_reg[1];
            chosen_cls = CLS_UNOWNED;
        end else if (cand_vld_reg[2]) begin
            chosen     = cand_frame_reg[2];
            chosen_cls = CLS_SAME_OWNER;
        end else begin
            chosen     = cand_frame_reg[3];
            chosen_cls = CLS_RANDOM;
        end
    end

    assign pt_raddr = pg_issue ? {pid_reg, pg_ptr_reg[PAGE_W-1:0]} : {pid_reg, page_reg};

    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = {pid_reg, page_reg};
        pt_wd    = '0;
        if (cmd.clr_run) begin
            pt_we    = 1'b1;
            pt_waddr = clr_reg;
        end else if (cmd.hit_wr) begin
            pt_we      = 1'b1;
            pt_wd      = pe_rd;
            pt_wd.refd = 1'b1;
        end else if (cmd.fill_wr || cmd.commit_b) begin
            pt_we       = 1'b1;
            pt_wd.cnt   = COUNTER_FULL;
            pt_wd.valid = 1'b1;
            pt_wd.refd  = 1'b1;
            pt_wd.frame = cmd.fill_wr ? pl_idx_reg : chosen;
        end else if (cmd.st_map) begin
            pt_we       = 1'b1;
            pt_waddr    = {pid_reg, st_page_reg};
            pt_wd.cnt   = COUNTER_FULL;
            pt_wd.valid = 1'b1;
            pt_wd.refd  = 1'b1;
            pt_wd.frame = pl_idx_reg;
        end else if (age_wr) begin
            pt_we       = 1'b1;
            pt_waddr    = {pid_reg, pg_idx_reg};
            pt_wd.cnt   = {pe_rd.refd, pe_rd.cnt[CNT_W-1:1]};
            pt_wd.valid = 1'b1;
            pt_wd.frame = pe_rd.frame;
        end else if (rel_wr) begin
            pt_we    = 1'b1;
            pt_waddr = {pid_reg, pg_idx_reg};
        end else if (cmd.commit_a) begin
            pt_we    = 1'b1;
            pt_waddr = {pid_reg, best_page_reg};
        end
    end

    always_comb begin
        pool_we    = 1'b0;
        pool_waddr = pl_idx_reg;
        pool_wd    = '0;
        if (cmd.clr_run) begin
            pool_we      = {1'b0, clr_reg} < (PT_AW+1)'(NUM_FRAMES);
            pool_waddr   = clr_reg[FRAME_W-1:0];
            pool_wd.free = 1'b1;
        end else if (cmd.fill_wr || cmd.st_map) begin
            pool_we = 1'b1;
        end else if (rel_wr) begin
            pool_we      = 1'b1;
            pool_waddr   = pe_rd.frame;
            pool_wd.free = 1'b1;
        end else if (cmd.commit_a) begin
            pool_we    = 1'b1;
            pool_waddr = chosen;
        end else if (cmd.commit_b) begin
            pool_we       = 1'b1;
            pool_waddr    = best_frame_reg;
            pool_wd.free  = 1'b1;
            pool_wd.owned = 1'b1;
            pool_wd.pid   = pid_reg;
            pool_wd.page  = best_page_reg;
        end
    end

    always_comb begin
        fc_next = fc_reg;
        if (cmd.fill_wr || cmd.st_map) begin
            fc_next = fc_reg - 1'b1;
        end else if (rel_wr) begin
            fc_next = fc_reg + 1'b1;
        end
    end

    apru_ram #(.WIDTH(PTE_W), .DEPTH(PT_DEPTH)) u_pt_ram (
        .clk   (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wd),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    apru_ram #(.WIDTH(POOL_W), .DEPTH(NUM_FRAMES)) u_pool_ram (
        .clk   (aclk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wd),
        .raddr (pl_ptr_reg[FRAME_W-1:0]),
        .rdata (pool_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THR_RESET;
            rsv_reg       <= RSV_RESET;
            clr_reg       <= '0;
            fc_reg        <= FC_W'(NUM_FRAMES);
            pg_vld_reg    <= 1'b0;
            pl_vld_reg    <= 1'b0;
            pg_ptr_reg    <= '0;
            pg_end_reg    <= '0;
            pl_ptr_reg    <= '0;
            vic_found_reg <= 1'b0;
            cand_vld_reg  <= '0;
            k_reg         <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_FREE_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                    CFG_RESERVED_PAGES: rsv_reg <= cfg_wdata[RSV_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr_run) begin
                clr_reg <= clr_reg + 1'b1;
            end
            fc_reg <= fc_next;

            // no scan runs while a scan is started, so the valid flag drops by itself
            pg_vld_reg <= pg_issue;
            if (cmd.pg_init) begin
                vic_found_reg <= 1'b0;
                pg_ptr_reg    <= (cmd.pg_mode == PGM_START || cmd.pg_mode == PGM_RELEASE) ?
                                 '0 : rl;
                pg_end_reg    <= (cmd.pg_mode == PGM_START) ? rl :
                                 PG_CNT_W'(PAGES_PER_PROCESS);
            end else if (pg_issue) begin
                pg_ptr_reg <= pg_ptr_reg + 1'b1;
            end
            if (vic_upd) begin
                vic_found_reg <= 1'b1;
            end

            pl_vld_reg <= pl_issue;
            if (cmd.pl_init) begin
                pl_ptr_reg   <= '0;
                cand_vld_reg <= '0;
                k_reg        <= '0;
            end else begin
                if (pl_issue) begin
                    pl_ptr_reg <= pl_ptr_reg + 1'b1;
                end
                if (ch_upd) begin
                    k_reg <= k_reg + 1'b1;
                    if (pl_rd.owned && pl_rd.pid == pid_reg && pl_rd.page == page_reg) begin
                        cand_vld_reg[0] <= 1'b1;
                    end
                    if (!pl_rd.owned) begin
                        cand_vld_reg[1] <= 1'b1;
                    end
                    if (pl_rd.owned && pl_rd.pid == pid_reg) begin
                        cand_vld_reg[2] <= 1'b1;
                    end
                    if (k_reg == pick_c) begin
                        cand_vld_reg[3] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            pid_reg        <= in_pid;
            page_reg       <= in_page;
            pick_reg       <= in_pick;
            res_frame_reg  <= '0;
            res_cls_reg    <= '0;
            res_vpage_reg  <= '0;
            res_vframe_reg <= '0;
        end
        if (pg_issue) begin
            pg_idx_reg <= pg_ptr_reg[PAGE_W-1:0];
        end
        if (pl_issue) begin
            pl_idx_reg <= pl_ptr_reg[FRAME_W-1:0];
        end
        if (pg_hit) begin
            st_page_reg <= pg_idx_reg;
        end
        if (vic_upd) begin
            best_cnt_reg   <= pe_rd.cnt;
            best_page_reg  <= pg_idx_reg;
            best_frame_reg <= pe_rd.frame;
        end
        if (ch_upd) begin
            if (pl_rd.owned && pl_rd.pid == pid_reg && pl_rd.page == page_reg &&
                !cand_vld_reg[0]) begin
                cand_frame_reg[0] <= pl_idx_reg;
            end
            if (!pl_rd.owned && !cand_vld_reg[1]) begin
                cand_frame_reg[1] <= pl_idx_reg;
            end
            if (pl_rd.owned && pl_rd.pid == pid_reg && !cand_vld_reg[2]) begin
                cand_frame_reg[2] <= pl_idx_reg;
            end
            if (k_reg == pick_c && !cand_vld_reg[3]) begin
                cand_frame_reg[3] <= pl_idx_reg;
            end
        end
        if (cmd.hit_wr) begin
            res_frame_reg <= pe_rd.frame;
        end
        if (cmd.fill_wr) begin
            res_frame_reg <= pl_idx_reg;
        end
        if (cmd.commit_b) begin
            res_frame_reg  <= chosen;
            res_cls_reg    <= chosen_cls;
            res_vpage_reg  <= best_page_reg;
            res_vframe_reg <= best_frame_reg;
        end
        if (cmd.out_ld) begin
            out_frame_reg  <= res_frame_reg;
            out_status_reg <= cmd.st;
            out_cls_reg    <= res_cls_reg;
            out_vpage_reg  <= res_vpage_reg;
            out_vframe_reg <= res_vframe_reg;
        end
    end

    assign stat.clr_last  = (clr_reg == PT_AW'(PT_DEPTH - 1));
    assign stat.pe_valid  = pe_rd.valid;
    assign stat.fc_gt_thr = 32'(fc_reg) > 32'(thr_reg);
    assign stat.fc_zero   = (fc_reg == '0);
    assign stat.vic_found = vic_found_reg;
    assign stat.pg_hit    = pg_hit;
    assign stat.pg_end    = pg_end;
    assign stat.pl_hit    = pl_hit;
    assign stat.pl_end    = pl_end;

    assign out_frame  = out_frame_reg;
    assign out_status = out_status_reg;
    assign out_cls    = out_cls_reg;
    assign out_vpage  = out_vpage_reg;
    assign out_vframe = out_vframe_reg;
endmodule
`default_nettype wire
